// ===== hw/rtl/bss_pkg.sv =====
// Shared widths, constants and result type for the bitset set similarity block.
package bss_pkg;

    localparam int IN_WORD_W = 64;
    localparam int INTER_W   = 13;
    localparam int FRAC_BITS = 16;
    localparam int RATIO_W   = FRAC_BITS + 1;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [INTER_W-1:0] intersection;
        logic [RATIO_W-1:0] jaccard;
        logic [RATIO_W-1:0] overlap;
    } bss_result_t;

endpackage

// ===== hw/rtl/bitset_set_similarity.sv =====
// Top level of the bitset set similarity block (Jaccard index and overlap coefficient).
//
//   channel | direction | handshake          | beat payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | input     | in_valid/in_ready  | word_a, word_b, last_word
//   out     | output    | out_valid/out_ready| common_size, jaccard_index,
//           |           |                    | overlap_coefficient
//
// Input words are taken one per cycle; popcount and accumulation are two pipeline stages.
// Each last word hands its counts to a two-entry queue; the back end then works through
// each result (load, 2 x 17 divider steps, output write) in one shared divider.
// Words keep flowing while the back end divides; input stalls only when a last word
// finds the queue full. Reset clears the running counts, the queue and the output valid.
module bitset_set_similarity #(
    parameter int WORD_BITS    = 64,
    parameter int MAX_SET_BITS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bss_pkg::IN_WORD_W-1:0] word_a,
    input  logic [bss_pkg::IN_WORD_W-1:0] word_b,
    input  logic                          last_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bss_pkg::INTER_W-1:0]   common_size,
    output logic [bss_pkg::RATIO_W-1:0]   jaccard_index,
    output logic [bss_pkg::RATIO_W-1:0]   overlap_coefficient
);
    import bss_pkg::*;

    localparam int CW = $clog2(MAX_SET_BITS + 1);
    localparam int DW = 4 * CW;

    logic          push_valid;
    logic          push_ready;
    logic [DW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [DW-1:0] pop_data;
    bss_result_t   result;

    bss_front #(
        .WORD_BITS    (WORD_BITS),
        .MAX_SET_BITS (MAX_SET_BITS),
        .CW           (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .word_a     (word_a),
        .word_b     (word_b),
        .last_word  (last_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bss_queue #(
        .DW    (DW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bss_back #(
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign common_size         = result.intersection;
    assign jaccard_index       = result.jaccard;
    assign overlap_coefficient = result.overlap;

endmodule

// ===== hw/rtl/bss_front.sv =====
// Front end: masks incoming words, popcounts them and accumulates the four set counts.
module bss_front #(
    parameter int WORD_BITS    = 64,
    parameter int MAX_SET_BITS = 4096,
    parameter int CW           = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bss_pkg::IN_WORD_W-1:0] word_a,
    input  logic [bss_pkg::IN_WORD_W-1:0] word_b,
    input  logic                          last_word,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [4*CW-1:0]               push_data
);
    import bss_pkg::*;

    localparam int NB = (WORD_BITS + 7) / 8;
    localparam int PB = NB * 8;
    localparam int SW = $clog2(PB + 1);
    localparam logic [IN_WORD_W-1:0] WORD_MASK =
        {IN_WORD_W{1'b1}} >> (IN_WORD_W - WORD_BITS);
    localparam logic [CW:0] MAX_CNT = (CW + 1)'(MAX_SET_BITS);

    // count index: 0 = A, 1 = B, 2 = A and B, 3 = A or B
    logic [IN_WORD_W-1:0] a_masked;
    logic [IN_WORD_W-1:0] b_masked;
    logic [PB-1:0]        vec [4];
    logic [3:0]           byte_cnt_next [4][NB];
    logic [3:0]           byte_cnt_reg  [4][NB];
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_last_reg;
    logic                 s1_last_next;
    logic [SW-1:0]        word_sum [4];
    logic [CW:0]          tot [4];
    logic [CW-1:0]        sat [4];
    logic [CW-1:0]        acc_reg  [4];
    logic [CW-1:0]        acc_next [4];
    logic                 consume;

    // drop bits above the configured word size
    assign a_masked = word_a & WORD_MASK;
    assign b_masked = word_b & WORD_MASK;
    assign vec[0]   = a_masked[PB-1:0];
    assign vec[1]   = b_masked[PB-1:0];
    assign vec[2]   = a_masked[PB-1:0] & b_masked[PB-1:0];
    assign vec[3]   = a_masked[PB-1:0] | b_masked[PB-1:0];

    // count each byte of each vector
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                byte_cnt_next[k][j] = 4'd0;
                for (int i = 0; i < 8; i++)
                begin
                    byte_cnt_next[k][j] = byte_cnt_next[k][j] + 4'(vec[k][j*8+i]);
                end
            end
        end
    end

    // hold stage one while a finished pair cannot enter the queue
    assign in_ready      = !(s1_valid_reg && s1_last_reg && !push_ready);
    assign consume       = s1_valid_reg && in_ready;
    assign s1_valid_next = in_ready ? in_valid  : s1_valid_reg;
    assign s1_last_next  = in_ready ? last_word : s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // sum the byte counts and add to the running totals, saturating at the set limit
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            word_sum[k] = '0;
            for (int j = 0; j < NB; j++)
            begin
                word_sum[k] = word_sum[k] + SW'(byte_cnt_reg[k][j]);
            end
            tot[k] = (CW + 1)'(acc_reg[k]) + (CW + 1)'(word_sum[k]);
            sat[k] = (tot[k] > MAX_CNT) ? MAX_CNT[CW-1:0] : tot[k][CW-1:0];
            if (consume)
            begin
                acc_next[k] = s1_last_reg ? '0 : sat[k];
            end
            else
            begin
                acc_next[k] = acc_reg[k];
            end
        end
    end

    // hand a finished pair to the back end: common, either, first, second
    assign push_valid = s1_valid_reg && s1_last_reg;
    assign push_data  = {sat[2], sat[3], sat[0], sat[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_last_reg  <= s1_last_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/bss_queue.sv =====
// Short FIFO between the counting front end and the dividing back end.
module bss_queue #(
    parameter int DW    = 52,
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);
    import bss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/bss_back.sv =====
// Back end: shared restoring divider for both Q1.16 ratios, plus the output register.
module bss_back #(
    parameter int CW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [4*CW-1:0]      pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bss_pkg::bss_result_t result
);
    import bss_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam logic [4:0] LAST_STEP = 5'(FRAC_BITS);

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [4:0]          step_reg;
    logic [4:0]          step_next;
    logic                pass_reg;
    logic                pass_next;
    logic [CW-1:0]       num_reg;
    logic [CW-1:0]       num_next;
    logic [CW-1:0]       jden_reg;
    logic [CW-1:0]       jden_next;
    logic [CW-1:0]       oden_reg;
    logic [CW-1:0]       oden_next;
    logic [CW:0]         rem_reg;
    logic [CW:0]         rem_next;
    logic [RATIO_W-1:0]  quo_reg;
    logic [RATIO_W-1:0]  quo_next;
    logic [RATIO_W-1:0]  jac_reg;
    logic [RATIO_W-1:0]  jac_next;
    logic [RATIO_W-1:0]  ovl_reg;
    logic [RATIO_W-1:0]  ovl_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    bss_result_t         result_reg;
    bss_result_t         result_next;

    logic [CW-1:0]       in_common;
    logic [CW-1:0]       in_either;
    logic [CW-1:0]       in_first;
    logic [CW-1:0]       in_second;
    logic [CW-1:0]       cur_den;
    logic [CW:0]         shifted;
    logic                ge;
    logic [RATIO_W-1:0]  quo_final;
    logic [RATIO_W-1:0]  ratio;
    logic [CW+INTER_W-1:0] inter_wide;

    assign {in_common, in_either, in_first, in_second} = pop_data;

    // one quotient bit per cycle; the first step tests the unshifted numerator
    assign cur_den   = pass_reg ? oden_reg : jden_reg;
    assign shifted   = (step_reg == '0) ? rem_reg : {rem_reg[CW-1:0], 1'b0};
    assign ge        = (shifted >= {1'b0, cur_den});
    assign quo_final = {quo_reg[RATIO_W-2:0], ge};
    assign ratio     = (cur_den == '0) ? RATIO_ONE : quo_final;

    assign inter_wide = {{INTER_W{1'b0}}, num_reg};

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // sequence load, two divisions and the output write
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        num_next       = num_reg;
        jden_next      = jden_reg;
        oden_next      = oden_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        jac_next       = jac_reg;
        ovl_next       = ovl_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    num_next   = in_common;
                    jden_next  = in_either;
                    oden_next  = (in_first < in_second) ? in_first : in_second;
                    rem_next   = {1'b0, in_common};
                    quo_next   = '0;
                    step_next  = '0;
                    pass_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? (shifted - {1'b0, cur_den}) : shifted;
                quo_next  = quo_final;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    rem_next  = {1'b0, num_reg};
                    quo_next  = '0;
                    if (!pass_reg)
                    begin
                        jac_next  = ratio;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        ovl_next   = ratio;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    result_next.intersection = inter_wide[INTER_W-1:0];
                    result_next.jaccard      = jac_reg;
                    result_next.overlap      = ovl_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        jden_reg   <= jden_next;
        oden_reg   <= oden_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        jac_reg    <= jac_next;
        ovl_reg    <= ovl_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/bss_checker.sv =====
// Port-level assertions for the bitset set similarity block, bound to the top level.
module bss_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bss_pkg::INTER_W-1:0] common_size,
    input logic [bss_pkg::RATIO_W-1:0] jaccard_index,
    input logic [bss_pkg::RATIO_W-1:0] overlap_coefficient
);
    import bss_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(common_size)
            && $stable(jaccard_index) && $stable(overlap_coefficient))
        else $error("result changed while stalled");

    // both ratios stay within 1.0
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> jaccard_index <= RATIO_ONE && overlap_coefficient <= RATIO_ONE)
        else $error("ratio above 1.0");

    // union is never smaller than the smaller set
    a_jac_le_ovl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> jaccard_index <= overlap_coefficient)
        else $error("jaccard index above overlap coefficient");

    // identical sets give a full overlap as well
    a_full_jac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && jaccard_index == RATIO_ONE |-> overlap_coefficient == RATIO_ONE)
        else $error("full jaccard index without full overlap");

endmodule

bind bitset_set_similarity bss_checker u_bss_checker (.*);

// ===== bench/tb_top.sv =====
// Testbench for the bitset set similarity block: streamed word pairs, scored results checked.
`timescale 1ns / 100ps

module tb_top;
    import bss_pkg::*;

    localparam int SET_LIMIT    = 4096;
    localparam int WORDS_TOTAL  = 900;
    localparam int IDLE_PCT     = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    typedef enum int
    {
        FILL_RANDOM,
        FILL_SPARSE,
        FILL_DENSE,
        FILL_SAME,
        FILL_A_EMPTY,
        FILL_B_EMPTY,
        FILL_NEAR
    } fill_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [IN_WORD_W-1:0] word_a    = '0;
    logic [IN_WORD_W-1:0] word_b    = '0;
    logic                 last_word = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [INTER_W-1:0]   common_size;
    logic [RATIO_W-1:0]   jaccard_index;
    logic [RATIO_W-1:0]   overlap_coefficient;

    // Running tallies of the predictor, cleared on every last word
    logic [INTER_W-1:0] tally_a   = '0;
    logic [INTER_W-1:0] tally_b   = '0;
    logic [INTER_W-1:0] tally_and = '0;
    logic [INTER_W-1:0] tally_or  = '0;

    bss_result_t expected_scores[$];
    int          mismatch_count = 0;
    int          scores_seen    = 0;
    int          words_sent     = 0;
    bit          idle_on        = 1'b1;
    int          hold_asked     = 0;
    int          hold_taken     = 0;
    int          hold_left      = 0;

    bitset_set_similarity uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .word_a              (word_a),
        .word_b              (word_b),
        .last_word           (last_word),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .common_size         (common_size),
        .jaccard_index       (jaccard_index),
        .overlap_coefficient (overlap_coefficient)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned bit_count(logic [IN_WORD_W-1:0] w);
        int unsigned n;
        n = 0;
        for (int i = 0; i < IN_WORD_W; i++)
            n += w[i];
        return n;
    endfunction

    // Add and clamp at the largest set size
    function automatic logic [INTER_W-1:0] clamp_add(logic [INTER_W-1:0] acc,
                                                     int unsigned add);
        int unsigned s;
        s = acc + add;
        return (s > SET_LIMIT) ? INTER_W'(SET_LIMIT) : INTER_W'(s);
    endfunction

    // Q1.16 quotient, truncated
    function automatic logic [RATIO_W-1:0] q16_ratio(logic [INTER_W-1:0] num,
                                                     logic [INTER_W-1:0] den);
        int unsigned scaled;
        scaled = num;
        scaled = scaled << FRAC_BITS;
        return RATIO_W'(scaled / den);
    endfunction

    // Fold one accepted beat into the tallies; score the pair on the last word
    task automatic tally_and_score(logic [IN_WORD_W-1:0] a, logic [IN_WORD_W-1:0] b,
                                   logic last);
        bss_result_t        score;
        logic [INTER_W-1:0] smaller;
        tally_a   = clamp_add(tally_a, bit_count(a));
        tally_b   = clamp_add(tally_b, bit_count(b));
        tally_and = clamp_add(tally_and, bit_count(a & b));
        tally_or  = clamp_add(tally_or, bit_count(a | b));
        if (last)
        begin
            score.intersection = tally_and;
            // Empty union counts as identical sets
            score.jaccard = (tally_or == 0) ? RATIO_ONE : q16_ratio(tally_and, tally_or);
            // Empty side counts as full overlap
            if (tally_a == 0 || tally_b == 0)
                score.overlap = RATIO_ONE;
            else
            begin
                smaller = (tally_a < tally_b) ? tally_a : tally_b;
                score.overlap = q16_ratio(tally_and, smaller);
            end
            expected_scores.push_back(score);
            tally_a   = '0;
            tally_b   = '0;
            tally_and = '0;
            tally_or  = '0;
        end
    endtask

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] score %0d: %s", $realtime, scores_seen, msg);
    endtask

    // Offer one beat, with an occasional gap ahead of it, and hold until taken
    task automatic send_word(logic [IN_WORD_W-1:0] a, logic [IN_WORD_W-1:0] b, logic last);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        word_a    <= a;
        word_b    <= b;
        last_word <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tally_and_score(a, b, last);
        words_sent++;
    endtask

    function automatic logic [IN_WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Send one vector pair of n_words beats, content shaped by mode
    task automatic send_vector(int n_words, fill_mode_t mode);
        logic [IN_WORD_W-1:0] a;
        logic [IN_WORD_W-1:0] b;
        for (int i = 0; i < n_words; i++)
        begin
            case (mode)
                FILL_SPARSE:
                begin
                    a = rand_word() & rand_word() & rand_word();
                    b = rand_word() & rand_word() & rand_word();
                end
                FILL_DENSE:
                begin
                    a = rand_word() | rand_word();
                    b = rand_word() | rand_word();
                end
                FILL_SAME:
                begin
                    a = rand_word();
                    b = a;
                end
                FILL_A_EMPTY:
                begin
                    a = '0;
                    b = rand_word();
                end
                FILL_B_EMPTY:
                begin
                    a = rand_word();
                    b = '0;
                end
                FILL_NEAR:
                begin
                    a = rand_word();
                    b = a ^ (rand_word() & rand_word() & rand_word());
                end
                default:
                begin
                    a = rand_word();
                    b = rand_word();
                end
            endcase
            // Sprinkle whole empty or full words
            if ($urandom_range(99) < 4)
                a = '0;
            else if ($urandom_range(99) < 4)
                a = '1;
            if ($urandom_range(99) < 4)
                b = '0;
            else if ($urandom_range(99) < 4)
                b = '1;
            send_word(a, b, i == n_words - 1);
        end
    endtask

    task automatic test_empty_and_full_sets();
        send_word('0, '0, 1'b1);
        send_word('0, '1, 1'b1);
        send_word('1, '0, 1'b1);
        send_word('1, '1, 1'b1);
    endtask

    task automatic test_ratio_shapes();
        // disjoint, subset, and a pair whose quotients do not divide evenly
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        send_word(64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF, 1'b1);
        send_word(64'h0000_0000_0000_0007, 64'h0000_0000_0000_01FC, 1'b1);
    endtask

    task automatic test_multi_word();
        send_word(rand_word(), rand_word(), 1'b0);
        send_word(rand_word(), rand_word(), 1'b0);
        send_word(rand_word(), rand_word(), 1'b0);
        send_word(64'h8000_0000_0000_0001, 64'hC000_0000_0000_0000, 1'b1);
    endtask

    task automatic test_saturation();
        // every tally clamps
        for (int i = 0; i < 66; i++)
            send_word('1, '1, i == 65);
        // only the A and union tallies clamp
        for (int i = 0; i < 66; i++)
            send_word('1, 64'h0000_0000_FFFF_FFFF, i == 65);
    endtask

    task automatic test_back_to_back();
        idle_on <= 1'b0;
        for (int i = 0; i < 20; i++)
            send_vector($urandom_range(1, 8), fill_mode_t'($urandom_range(6)));
        idle_on <= 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 24; i++)
            send_vector(1, fill_mode_t'($urandom_range(6)));
    endtask

    task automatic test_random_vectors();
        int         pick;
        int         n_words;
        fill_mode_t mode;
        while (words_sent < WORDS_TOTAL)
        begin
            pick = $urandom_range(99);
            mode = fill_mode_t'($urandom_range(6));
            if (pick < 85)
                n_words = $urandom_range(1, 8);
            else if (pick < 98)
                n_words = $urandom_range(9, 40);
            else
            begin
                // long pair, mostly dense so the union tally may clamp
                n_words = $urandom_range(60, 70);
                if ($urandom_range(1))
                    mode = FILL_DENSE;
            end
            send_vector(n_words, mode);
        end
    endtask

    // Drive out_ready: random idling, plus a long hold when a test asks for one
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // Compare each result beat with the oldest pending score
    always @(posedge clk)
    begin
        bss_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_scores.size() == 0)
                note_mismatch("result beat with no score pending");
            else
            begin
                want = expected_scores.pop_front();
                if (common_size !== want.intersection)
                    note_mismatch($sformatf("intersection expected %0d, got %0d",
                                            want.intersection, common_size));
                if (jaccard_index !== want.jaccard)
                    note_mismatch($sformatf("jaccard expected %0d, got %0d",
                                            want.jaccard, jaccard_index));
                if (overlap_coefficient !== want.overlap)
                    note_mismatch($sformatf("overlap expected %0d, got %0d",
                                            want.overlap, overlap_coefficient));
            end
            scores_seen++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("bitset_set_similarity: mismatch");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_full_sets();
        test_ratio_shapes();
        test_multi_word();
        test_saturation();
        test_back_to_back();
        test_output_backpressure();
        test_random_vectors();
        in_valid <= 1'b0;

        // Wait until every pending score is checked, then idle for DRAIN_CYCLES to catch stray beats
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("bitset_set_similarity: match");
        else
            $display("bitset_set_similarity: mismatch");
        $finish;
    end

endmodule
